[rtl/mrxy_pkg.sv]
// shared types, port codes and helper functions of the mesh router allocator
// no dependencies
`default_nettype none

package mrxy_pkg;

	localparam int COORD_BITS = 4;
	localparam int NPORTS     = 5;
	localparam int PORT_BITS  = 3;

	localparam int IN_DATA_BITS  = 56;
	localparam int OUT_DATA_BITS = 32;

	typedef logic [COORD_BITS-1:0] coord_t;
	typedef logic [NPORTS-1:0]     port_mask_t;
	typedef logic [PORT_BITS-1:0]  port_idx_t;

	typedef enum logic [PORT_BITS-1:0] {
		PORT_RIGHT = 3'd0,
		PORT_LEFT  = 3'd1,
		PORT_UP    = 3'd2,
		PORT_DOWN  = 3'd3,
		PORT_LOCAL = 3'd4
	} port_t;

	typedef enum logic {
		CFG_ROUTER_X = 1'b0,
		CFG_ROUTER_Y = 1'b1
	} cfg_index_t;

	typedef struct packed {
		logic      hit;
		port_idx_t idx;
	} arb_t;

	// dimension-ordered routing, x first
	function automatic port_t route_port(coord_t dx, coord_t dy, coord_t mx, coord_t my);
		port_t p;
		begin
			if (dx != mx) begin
				p = (dx < mx) ? PORT_LEFT : PORT_RIGHT;
			end else if (dy != my) begin
				p = (dy < my) ? PORT_DOWN : PORT_UP;
			end else begin
				p = PORT_LOCAL;
			end
			return p;
		end
	endfunction

	// round-robin pick starting at ptr
	function automatic arb_t rr_pick(port_mask_t req, port_idx_t ptr);
		arb_t                 r;
		logic [PORT_BITS:0]   sum;
		port_idx_t            cand;
		begin
			r = '0;
			for (int c = 0; c < NPORTS; c++) begin
				sum = {1'b0, ptr} + (PORT_BITS+1)'(c);
				if (sum >= (PORT_BITS+1)'(NPORTS)) begin
					sum = sum - (PORT_BITS+1)'(NPORTS);
				end
				cand = sum[PORT_BITS-1:0];
				if (!r.hit && req[cand]) begin
					r.hit = 1'b1;
					r.idx = cand;
				end
			end
			return r;
		end
	endfunction

	function automatic port_idx_t next_ptr(port_idx_t idx);
		port_idx_t n;
		begin
			if (idx == port_idx_t'(NPORTS - 1)) begin
				n = '0;
			end else begin
				n = idx + port_idx_t'(1);
			end
			return n;
		end
	endfunction

endpackage

`default_nettype wire

[rtl/mesh_router_xy_wormhole_allocator_core.sv]
// top level of the five-port mesh router switch allocator
// depends on mrxy_pkg
`default_nettype none

// Switch allocator for a five-port mesh router (right, left, up, down, local).
// Each request carries the five queue heads and an output-room mask; every head
// is routed x first then y against router_x/router_y, and each output with room
// picks a winner round-robin from its pointer, honoring its wormhole lock until
// the last flit of the holding packet. A request is registered on entry, then
// routing and arbitration settle combinationally into the result register; one
// request is taken every cycle unless m_axis_tready holds a full result register,
// and the per-output pointer and lock registers close their loop around that logic.
module mesh_router_xy_wormhole_allocator_core (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               s_axis_tvalid,
	output logic                              s_axis_tready,
	// head_valid[4:0], head_last[9:5], head_dest_x[29:10], head_dest_y[49:30],
	// output_room[54:50], zero pad
	input  wire  [mrxy_pkg::IN_DATA_BITS-1:0]  s_axis_tdata,
	output logic                              m_axis_tvalid,
	input  wire                               m_axis_tready,
	// grant_valid[4:0], granted_input[19:5], input_popped[24:20], zero pad
	output logic [mrxy_pkg::OUT_DATA_BITS-1:0] m_axis_tdata,
	input  wire                               cfg_we,
	input  wire                               cfg_index,
	input  wire  [mrxy_pkg::COORD_BITS-1:0]    cfg_data
);

	import mrxy_pkg::*;

	localparam int XY_BITS = NPORTS * COORD_BITS;
	localparam int GI_BITS = NPORTS * PORT_BITS;

	coord_t router_x_q;
	coord_t router_y_q;

	logic                valid_s1;
	port_mask_t          head_valid_s1;
	port_mask_t          head_last_s1;
	logic [XY_BITS-1:0]  head_dest_x_s1;
	logic [XY_BITS-1:0]  head_dest_y_s1;
	port_mask_t          output_room_s1;

	logic                valid_s2;
	port_mask_t          grant_valid_s2;
	logic [GI_BITS-1:0]  granted_input_s2;
	port_mask_t          input_popped_s2;

	port_idx_t           rr_ptr_q   [NPORTS];
	logic                lock_vld_q [NPORTS];
	port_idx_t           lock_in_q  [NPORTS];

	port_t               want       [NPORTS];
	port_mask_t          req        [NPORTS];
	arb_t                pick       [NPORTS];
	port_mask_t          grant_valid_d;
	logic [GI_BITS-1:0]  granted_input_d;
	port_mask_t          input_popped_d;

	logic                s2_ready;
	logic                advance;

	assign s2_ready      = !valid_s2 || m_axis_tready;
	assign advance       = valid_s1 && s2_ready;
	assign s_axis_tready = !valid_s1 || s2_ready;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			router_x_q <= '0;
			router_y_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index_t'(cfg_index))
				CFG_ROUTER_X: router_x_q <= cfg_data;
				CFG_ROUTER_Y: router_y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			head_valid_s1  <= s_axis_tdata[4:0];
			head_last_s1   <= s_axis_tdata[9:5];
			head_dest_x_s1 <= s_axis_tdata[29:10];
			head_dest_y_s1 <= s_axis_tdata[49:30];
			output_room_s1 <= s_axis_tdata[54:50];
		end
	end

	// routing and arbitration
	always_comb begin
		grant_valid_d   = '0;
		granted_input_d = '0;
		input_popped_d  = '0;
		for (int i = 0; i < NPORTS; i++) begin
			want[i] = route_port(head_dest_x_s1[i*COORD_BITS +: COORD_BITS],
				head_dest_y_s1[i*COORD_BITS +: COORD_BITS], router_x_q, router_y_q);
		end
		for (int o = 0; o < NPORTS; o++) begin
			for (int i = 0; i < NPORTS; i++) begin
				req[o][i] = head_valid_s1[i] && (want[i] == port_t'(PORT_BITS'(o))) &&
					(!lock_vld_q[o] || (lock_in_q[o] == port_idx_t'(i)));
			end
			pick[o] = rr_pick(req[o], rr_ptr_q[o]);
			if (output_room_s1[o] && pick[o].hit) begin
				grant_valid_d[o]                         = 1'b1;
				granted_input_d[o*PORT_BITS +: PORT_BITS] = pick[o].idx;
				input_popped_d[pick[o].idx]              = 1'b1;
			end
		end
	end

	// pointer and wormhole lock state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int o = 0; o < NPORTS; o++) begin
				rr_ptr_q[o]   <= '0;
				lock_vld_q[o] <= 1'b0;
				lock_in_q[o]  <= '0;
			end
		end else if (advance) begin
			for (int o = 0; o < NPORTS; o++) begin
				if (grant_valid_d[o]) begin
					rr_ptr_q[o] <= next_ptr(pick[o].idx);
					if (head_last_s1[pick[o].idx]) begin
						lock_vld_q[o] <= 1'b0;
						lock_in_q[o]  <= '0;
					end else begin
						lock_vld_q[o] <= 1'b1;
						lock_in_q[o]  <= pick[o].idx;
					end
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			grant_valid_s2   <= grant_valid_d;
			granted_input_s2 <= granted_input_d;
			input_popped_s2  <= input_popped_d;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {7'd0, input_popped_s2, granted_input_s2, grant_valid_s2};

	// checks
	a_pop_matches_grant: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> ($countones(grant_valid_s2) == $countones(input_popped_s2)))
		else $error("popped inputs differ from granted outputs");

	a_grant_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> ((grant_valid_s2 & ~$past(output_room_s1)) == '0))
		else $error("grant on an output without room");

	a_grant_needs_head: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> ((input_popped_s2 & ~$past(head_valid_s1)) == '0))
		else $error("pop of an input without a head");

	generate
		for (genvar g = 0; g < NPORTS; g++) begin : g_chk
			a_state_range: assert property (@(posedge clk) disable iff (!arst_n)
				(rr_ptr_q[g] < port_idx_t'(NPORTS)) && (lock_in_q[g] < port_idx_t'(NPORTS)))
				else $error("pointer or lock out of range");
		end
	endgenerate

endmodule

`default_nettype wire
